// File: rtl/base64_stream_encoder_macros.svh
// assertion helpers, clocked on clk with reset rst_n low
`ifndef BASE64_STREAM_ENCODER_MACROS_SVH
`define BASE64_STREAM_ENCODER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define B64E_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("b64e assertion failed");

// antecedent implies consequent in the following cycle
`define B64E_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("b64e assertion failed");

`endif

// File: rtl/b64e_pkg.sv
package b64e_pkg;

    localparam logic [6:0] PAD_CHAR = 7'd61;
    localparam int QDEPTH = 2;

    // up to four characters produced by one input byte
    typedef struct packed {
        logic [3:0][6:0] chars;
        logic [1:0]      cnt_m1;
        logic            last;
    } bundle_t;

    function automatic logic [6:0] sextet_char(input logic [5:0] v);
        logic [6:0] c;
        case (v) inside
            [6'd0:6'd25]:  c = 7'd65 + {1'b0, v};
            [6'd26:6'd51]: c = 7'd71 + {1'b0, v};
            [6'd52:6'd61]: c = {1'b0, v} - 7'd4;
            6'd62:         c = 7'd43;
            default:       c = 7'd47;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/base64_stream_encoder.sv
// base64 stream encoder: one byte in, one to four ascii characters out
// the first character of a byte passes through the queue entry and then the output register
// throughput: one character per cycle from the output register when m_tready is high;
//   a byte yields 1 or 2 characters, up to 4 on the last byte
// a two-entry queue decouples the byte side from the character serializer
// reset: rst_n low clears group position, leftover bits, queue and output valid
module base64_stream_encoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] data_byte
    input  logic       s_tlast,    // last_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [6:0] char_code, [7] zero
    output logic       m_tlast     // last_char
);
    import b64e_pkg::*;

    bundle_t push_data;
    bundle_t head;
    logic    push;
    logic    pop;
    logic    full;
    logic    not_empty;

    assign s_tready = !full;
    assign push     = s_tvalid && !full;

    b64e_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .bundle    (push_data)
    );

    b64e_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (full),
        .not_empty (not_empty),
        .head      (head)
    );

    b64e_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (not_empty),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// File: rtl/b64e_front.sv
`include "base64_stream_encoder_macros.svh"

module b64e_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    output b64e_pkg::bundle_t bundle
);
    import b64e_pkg::*;

    logic [1:0] group_position_reg, group_position_next;
    logic [3:0] leftover_bits_reg, leftover_bits_next;

    always_comb
    begin
        bundle              = '0;
        group_position_next = group_position_reg;
        leftover_bits_next  = leftover_bits_reg;
        case (group_position_reg)
            2'd1:
            begin
                bundle.chars[0] = sextet_char({leftover_bits_reg[1:0], data_byte[7:4]});
                if (last_byte)
                begin
                    bundle.chars[1]     = sextet_char({data_byte[3:0], 2'b00});
                    bundle.chars[2]     = PAD_CHAR;
                    bundle.cnt_m1       = 2'd2;
                    bundle.last         = 1'b1;
                    group_position_next = 2'd0;
                    leftover_bits_next  = 4'd0;
                end
                else
                begin
                    bundle.cnt_m1       = 2'd0;
                    group_position_next = 2'd2;
                    leftover_bits_next  = data_byte[3:0];
                end
            end
            2'd2:
            begin
                bundle.chars[0]     = sextet_char({leftover_bits_reg, data_byte[7:6]});
                bundle.chars[1]     = sextet_char(data_byte[5:0]);
                bundle.cnt_m1       = 2'd1;
                bundle.last         = last_byte;
                group_position_next = 2'd0;
                leftover_bits_next  = 4'd0;
            end
            default:
            begin
                bundle.chars[0] = sextet_char(data_byte[7:2]);
                if (last_byte)
                begin
                    bundle.chars[1]     = sextet_char({data_byte[1:0], 4'b0000});
                    bundle.chars[2]     = PAD_CHAR;
                    bundle.chars[3]     = PAD_CHAR;
                    bundle.cnt_m1       = 2'd3;
                    bundle.last         = 1'b1;
                    group_position_next = 2'd0;
                    leftover_bits_next  = 4'd0;
                end
                else
                begin
                    bundle.cnt_m1       = 2'd0;
                    group_position_next = 2'd1;
                    leftover_bits_next  = {2'b00, data_byte[1:0]};
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_position_reg <= 2'd0;
            leftover_bits_reg  <= 4'd0;
        end
        else if (push)
        begin
            group_position_reg <= group_position_next;
            leftover_bits_reg  <= leftover_bits_next;
        end
    end

    `B64E_ASSERT_SAME(a_pos_legal, 1'b1, group_position_reg != 2'd3)
    `B64E_ASSERT_NEXT(a_last_restarts, push && last_byte, group_position_reg == 2'd0)

endmodule

// File: rtl/b64e_queue.sv
`include "base64_stream_encoder_macros.svh"

module b64e_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  b64e_pkg::bundle_t push_data,
    input  logic              pop,
    output logic              full,
    output logic              not_empty,
    output b64e_pkg::bundle_t head
);
    import b64e_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    bundle_t            entry_reg [QDEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full      = (count_reg == CNT_W'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `B64E_ASSERT_SAME(a_no_overflow, push, !full)
    `B64E_ASSERT_SAME(a_no_underflow, pop, not_empty)

endmodule

// File: rtl/b64e_back.sv
`include "base64_stream_encoder_macros.svh"

module b64e_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  b64e_pkg::bundle_t head,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [6:0] char_code, [7] zero
    output logic              m_tlast    // last_char
);
    import b64e_pkg::*;

    logic [1:0] idx_reg;
    logic       valid_reg;
    logic [6:0] code_reg;
    logic       last_reg;
    logic       load;
    logic       final_char;

    assign load       = q_valid && (!valid_reg || m_tready);
    assign final_char = (idx_reg == head.cnt_m1);
    assign pop        = load && final_char;

    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, code_reg};
    assign m_tlast  = last_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            code_reg <= head.chars[idx_reg];
            last_reg <= head.last && final_char;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= final_char ? 2'd0 : idx_reg + 2'd1;
            end
            else if (m_tready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // the character index never runs past the head transaction's count
    `B64E_ASSERT_SAME(a_idx_in_range, q_valid, idx_reg <= head.cnt_m1)
    `B64E_ASSERT_NEXT(a_pop_rewinds, pop, idx_reg == 2'd0)

endmodule
